/* hw/rtl/nlt_pkg.sv */
// Package for the node liveness table: request, response and table entry types,
// action and status codes, and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package nlt_pkg;

   localparam logic [1:0] ACT_REGISTER  = 2'd0;
   localparam logic [1:0] ACT_HEARTBEAT = 2'd1;
   localparam logic [1:0] ACT_QUIT      = 2'd2;

   localparam logic [2:0] STATUS_REGISTERED = 3'd0;
   localparam logic [2:0] STATUS_FULL       = 3'd1;
   localparam logic [2:0] STATUS_IN_TIME    = 3'd2;
   localparam logic [2:0] STATUS_DEAD       = 3'd3;
   localparam logic [2:0] STATUS_NOT_FOUND  = 3'd4;
   localparam logic [2:0] STATUS_QUIT_DONE  = 3'd5;

   localparam logic [31:0] TOLERANCE_RESET = 32'd10;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] node_ip;
      logic [15:0] node_port;
      logic [31:0] msg_time;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] entry_index;
      logic       entry_live;
   } rsp_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] port;
      logic [31:0] stamp;
      logic        alive;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       scan_start;
      logic       scan_step;
      logic       commit;
      logic [2:0] status;
   } ctl_cmd_type;

   typedef struct packed {
      logic full;
      logic hit;
      logic miss;
      logic late;
      logic out_free;
   } dp_status_type;

endpackage

/* hw/rtl/node_liveness_table_unit.sv */
// Top level of the node liveness table: heartbeat liveness monitor over a node table.
// Depends on nlt_pkg, nlt_ctrl, nlt_datapath (which holds nlt_ram).
//
// Usage:
//   req_* carries one message (register, heartbeat, quit); it is taken when req_valid
//   is high and req_stall low. rsp_* returns exactly one response per request under
//   the same valid/stall rule. csr_wr_en/csr_wr_data write the tolerance register;
//   the user writes it only while no request is in flight; the block does not check.
// Request flow:
//   A register or unknown action goes from acceptance to the finish state. A
//   heartbeat or quit scans the table one entry per cycle through the entry RAM read
//   port until a match or the end of the used entries, then finishes. One request is
//   in work at a time; the next is taken in the idle state, which the controller
//   enters as the response is loaded into the output register.
// Reset:
//   Synchronous, active high. The table empties (entry count zero), tolerance
//   returns to 10, no response is pending. The RAM itself is not cleared.
// Receiver stall:
//   The response register holds its value; a finished request waits in the
//   controller until the register frees, while new requests are stalled.
`timescale 1ns / 1ps

module node_liveness_table_unit #(
   parameter int MAX_NODES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nlt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nlt_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);
   nlt_pkg::ctl_cmd_type   cmd;
   nlt_pkg::dp_status_type dp_status;

   nlt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   nlt_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> dp_status.out_free)
      else $error("response committed while output register busy");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one still in work");

   a_hit_miss_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !(dp_status.hit && dp_status.miss))
      else $error("scan reports hit and miss together");

   a_commit_single: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !cmd.commit)
      else $error("two commits for one request");

endmodule

/* hw/rtl/nlt_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nlt_ram #(
   parameter int WIDTH = 81,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/nlt_ctrl.sv */
// Controller state machine for the node liveness table.
// Depends on nlt_pkg.
`timescale 1ns / 1ps

module nlt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_action,
   output logic                  req_stall,
   input  nlt_pkg::dp_status_type dp_status,
   output nlt_pkg::ctl_cmd_type  cmd
);
   nlt_pkg::state_type state_ff, state_in;
   logic [1:0] action_ff, action_in;
   logic       found_ff, found_in;
   logic [2:0] status_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= nlt_pkg::S_IDLE;
         action_ff <= nlt_pkg::ACT_REGISTER;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         action_ff <= action_in;
         found_ff  <= found_in;
      end
   end

   always_comb begin
      case (action_ff)
         nlt_pkg::ACT_REGISTER:
            status_sel = dp_status.full ? nlt_pkg::STATUS_FULL : nlt_pkg::STATUS_REGISTERED;
         nlt_pkg::ACT_HEARTBEAT:
            status_sel = !found_ff ? nlt_pkg::STATUS_NOT_FOUND :
                         dp_status.late ? nlt_pkg::STATUS_DEAD : nlt_pkg::STATUS_IN_TIME;
         nlt_pkg::ACT_QUIT:
            status_sel = found_ff ? nlt_pkg::STATUS_QUIT_DONE : nlt_pkg::STATUS_NOT_FOUND;
         default:
            status_sel = nlt_pkg::STATUS_NOT_FOUND;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      action_in      = action_ff;
      found_in       = found_ff;
      req_stall      = 1'b1;
      cmd            = '0;
      cmd.status     = status_sel;
      unique case (state_ff)
         nlt_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               action_in    = req_action;
               found_in     = 1'b0;
               if (req_action == nlt_pkg::ACT_HEARTBEAT || req_action == nlt_pkg::ACT_QUIT) begin
                  cmd.scan_start = 1'b1;
                  state_in       = nlt_pkg::S_SCAN;
               end else begin
                  state_in = nlt_pkg::S_FINISH;
               end
            end
         end
         nlt_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (dp_status.hit) begin
               found_in = 1'b1;
               state_in = nlt_pkg::S_FINISH;
            end else if (dp_status.miss) begin
               state_in = nlt_pkg::S_FINISH;
            end
         end
         nlt_pkg::S_FINISH: begin
            if (dp_status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = nlt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = nlt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/nlt_datapath.sv */
// Datapath for the node liveness table: request and tolerance registers, entry count,
// scan pointer and compare stage, entry RAM and response register.
// Depends on nlt_pkg and nlt_ram.
`timescale 1ns / 1ps

module nlt_datapath #(
   parameter int MAX_NODES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nlt_pkg::req_type       req_data,
   input  logic                   csr_wr_en,
   input  logic [31:0]            csr_wr_data,
   input  nlt_pkg::ctl_cmd_type   cmd,
   output nlt_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output nlt_pkg::rsp_type       rsp_data
);
   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int ENTRY_W = $bits(nlt_pkg::entry_type);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NODES);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   nlt_pkg::req_type   req_ff;
   logic [31:0]        tolerance_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   scan_ptr_ff, scan_ptr_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]   chk_idx_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [31:0]        hit_time_ff;
   logic               hit_alive_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   nlt_pkg::rsp_type   rsp_ff, rsp_in;

   logic               issue_ok;
   logic               hit;
   logic               rd_en;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   nlt_pkg::entry_type wr_entry;
   nlt_pkg::entry_type rd_entry;
   logic [ENTRY_W-1:0] rd_bits;
   logic [31:0]        gap;
   logic               out_free;

   nlt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_NODES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (scan_ptr_ff[IDX_W-1:0]),
      .rd_data (rd_bits)
   );

   assign rd_entry = nlt_pkg::entry_type'(rd_bits);
   assign issue_ok = scan_ptr_ff < count_ff;
   assign hit      = chk_valid_ff && rd_entry.addr == req_ff.node_ip
                     && rd_entry.port == req_ff.node_port;
   assign rd_en    = cmd.scan_step && issue_ok && !hit;
   assign gap      = req_ff.msg_time - hit_time_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      dp_status.full     = count_ff == CNT_MAX;
      dp_status.hit      = hit;
      dp_status.miss     = !chk_valid_ff && !issue_ok;
      dp_status.late     = gap > tolerance_ff;
      dp_status.out_free = out_free;
   end

   always_comb begin
      scan_ptr_in  = scan_ptr_ff;
      chk_valid_in = chk_valid_ff;
      if (cmd.scan_start) begin
         scan_ptr_in  = '0;
         chk_valid_in = 1'b0;
      end else if (cmd.scan_step) begin
         chk_valid_in = rd_en;
         if (rd_en) begin
            scan_ptr_in = scan_ptr_ff + CNT_ONE;
         end
      end
   end

   always_comb begin
      wr_en          = 1'b0;
      wr_addr        = hit_idx_ff;
      wr_entry.addr  = req_ff.node_ip;
      wr_entry.port  = req_ff.node_port;
      wr_entry.stamp = req_ff.msg_time;
      wr_entry.alive = 1'b0;
      count_in       = count_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = cmd.status;
         rsp_in.entry_index = 4'(hit_idx_ff);
         rsp_in.entry_live  = 1'b0;
         case (cmd.status)
            nlt_pkg::STATUS_REGISTERED: begin
               wr_en              = 1'b1;
               wr_addr            = count_ff[IDX_W-1:0];
               wr_entry.alive     = 1'b1;
               count_in           = count_ff + CNT_ONE;
               rsp_in.entry_index = 4'(count_ff[IDX_W-1:0]);
               rsp_in.entry_live  = 1'b1;
            end
            nlt_pkg::STATUS_IN_TIME: begin
               wr_en             = 1'b1;
               wr_entry.alive    = hit_alive_ff;
               rsp_in.entry_live = hit_alive_ff;
            end
            nlt_pkg::STATUS_DEAD: begin
               wr_en = 1'b1;
            end
            nlt_pkg::STATUS_QUIT_DONE: begin
               wr_en          = 1'b1;
               wr_entry.stamp = hit_time_ff;
            end
            default: begin
               rsp_in.entry_index = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= nlt_pkg::TOLERANCE_RESET;
         count_ff     <= '0;
         scan_ptr_ff  <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tolerance_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         scan_ptr_ff  <= scan_ptr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      chk_idx_ff <= scan_ptr_ff[IDX_W-1:0];
      if (cmd.scan_step && hit) begin
         hit_idx_ff   <= chk_idx_ff;
         hit_time_ff  <= rd_entry.stamp;
         hit_alive_ff <= rd_entry.alive;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/sv/node_liveness_table_unit_test.sv */
// Self-checking bench for node_liveness_table_unit: directed message table, then random
// register/heartbeat/quit and unknown-action traffic under several tolerance settings.
// Depends on nlt_pkg and node_liveness_table_unit.
`timescale 1ns / 1ps

module node_liveness_table_unit_test;

   localparam int TABLE_DEPTH = 16;
   localparam int PHASE_ITEMS = 180;
   localparam int HOLD_AFTER  = 400;
   localparam int HOLD_CYCLES = 400;
   localparam int TIMEOUT_NS  = 2_000_000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      nlt_pkg::req_type r;
      bit               typed;
      nlt_pkg::rsp_type want;
   } dir_row_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   nlt_pkg::req_type req_data    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   nlt_pkg::rsp_type rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [31:0]      csr_wr_data = '0;

   // shadow of the node table
   logic [31:0] tab_addr  [TABLE_DEPTH];
   logic [15:0] tab_port  [TABLE_DEPTH];
   logic [31:0] tab_stamp [TABLE_DEPTH];
   logic        tab_alive [TABLE_DEPTH];
   int          tab_count = 0;
   logic [31:0] tol_setting = nlt_pkg::TOLERANCE_RESET;

   nlt_pkg::rsp_type awaited_rsp[$];
   dir_row_type      dir_rows[$];
   int               error_count = 0;
   int               rsp_seen = 0;

   int          hold_left = 0;
   bit          hold_done = 0;
   int          stall_mode = 0;
   int          mode_left = 0;
   int          stall_phase = 0;

   node_liveness_table_unit #(.MAX_NODES(TABLE_DEPTH)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("node_liveness_table_unit_test: errors");
      $finish;
   end

   function automatic int find_entry(logic [31:0] ip, logic [15:0] port);
      int k;
      for (k = 0; k < tab_count; k++) begin
         if (tab_addr[k] == ip && tab_port[k] == port) return k;
      end
      return -1;
   endfunction

   function automatic nlt_pkg::rsp_type predict_liveness(nlt_pkg::req_type r);
      nlt_pkg::rsp_type o;
      int               h;
      logic [31:0]      gap;
      o.status      = nlt_pkg::STATUS_NOT_FOUND;
      o.entry_index = '0;
      o.entry_live  = 1'b0;
      case (r.action)
         nlt_pkg::ACT_REGISTER: begin
            if (tab_count < TABLE_DEPTH) begin
               tab_addr[tab_count]  = r.node_ip;
               tab_port[tab_count]  = r.node_port;
               tab_stamp[tab_count] = r.msg_time;
               tab_alive[tab_count] = 1'b1;
               o.status      = nlt_pkg::STATUS_REGISTERED;
               o.entry_index = 4'(tab_count);
               o.entry_live  = 1'b1;
               tab_count++;
            end else begin
               o.status = nlt_pkg::STATUS_FULL;
            end
         end
         nlt_pkg::ACT_HEARTBEAT: begin
            h = find_entry(r.node_ip, r.node_port);
            if (h >= 0) begin
               gap = r.msg_time - tab_stamp[h];
               if (gap > tol_setting) begin
                  tab_alive[h] = 1'b0;
                  o.status = nlt_pkg::STATUS_DEAD;
               end else begin
                  o.status = nlt_pkg::STATUS_IN_TIME;
               end
               tab_stamp[h]  = r.msg_time;
               o.entry_index = 4'(h);
               o.entry_live  = tab_alive[h];
            end
         end
         nlt_pkg::ACT_QUIT: begin
            h = find_entry(r.node_ip, r.node_port);
            if (h >= 0) begin
               tab_alive[h]  = 1'b0;
               o.status      = nlt_pkg::STATUS_QUIT_DONE;
               o.entry_index = 4'(h);
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic nlt_pkg::req_type gen_message();
      nlt_pkg::req_type r;
      int               sel;
      int               k;
      int               h;
      logic [31:0]      gap;
      r.action    = nlt_pkg::ACT_REGISTER;
      r.node_ip   = $urandom;
      r.node_port = 16'($urandom);
      r.msg_time  = $urandom;
      sel = $urandom_range(0, 99);
      if (tab_count == 0 && sel < 80) sel = 0;
      if (sel < 8) begin
         k = $urandom_range(0, 3);
         if (k == 0 && tab_count > 0) begin
            k = $urandom_range(0, tab_count - 1);
            r.node_ip   = tab_addr[k];
            r.node_port = tab_port[k];
         end else if (k == 1) begin
            r.node_ip   = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            r.node_port = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
         end
      end else if (sel < 80) begin
         k = $urandom_range(0, tab_count - 1);
         r.node_ip   = tab_addr[k];
         r.node_port = tab_port[k];
         h = find_entry(r.node_ip, r.node_port);
         case ($urandom_range(0, 5))
            0:       gap = '0;
            1:       gap = tol_setting;
            2:       gap = tol_setting + 32'd1;
            3:       gap = tol_setting - 32'd1;
            4:       gap = $urandom_range(0, 40);
            default: gap = $urandom;
         endcase
         r.msg_time = tab_stamp[h] + gap;
         r.action   = (sel < 76) ? nlt_pkg::ACT_HEARTBEAT : nlt_pkg::ACT_QUIT;
      end else begin
         r.action = 2'($urandom_range(0, 3));
         if (tab_count > 0 && $urandom_range(0, 1) == 1) begin
            k = $urandom_range(0, tab_count - 1);
            r.node_ip   = tab_addr[k];
            r.node_port = tab_port[k] ^ (16'h1 << $urandom_range(0, 15));
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic add_row(input logic [1:0] act, input logic [31:0] ip,
                          input logic [15:0] port, input logic [31:0] stamp,
                          input bit typed, input logic [2:0] st,
                          input logic [3:0] idx, input logic live);
      dir_row_type row;
      row.r.action         = act;
      row.r.node_ip        = ip;
      row.r.node_port      = port;
      row.r.msg_time       = stamp;
      row.typed            = typed;
      row.want.status      = st;
      row.want.entry_index = idx;
      row.want.entry_live  = live;
      dir_rows = {dir_rows, row};
   endtask

   task automatic send_request(input nlt_pkg::req_type r, input bit typed,
                               input nlt_pkg::rsp_type want);
      nlt_pkg::rsp_type predicted;
      nlt_pkg::rsp_type chosen;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = predict_liveness(r);
      chosen = typed ? want : predicted;
      awaited_rsp = {awaited_rsp, chosen};
   endtask

   task automatic pause_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [31:0] value);
      drain_responses();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= $urandom;
      tol_setting = value;
   endtask

   task automatic run_random_phase(input int count);
      int burst_left;
      int i;
      burst_left = 0;
      for (i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
         end
         send_request(gen_message(), 1'b0, '0);
         burst_left--;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      nlt_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsp_seen++;
         if (awaited_rsp.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_data.status, -1);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.entry_index !== want.entry_index)
               report_mismatch("entry_index", rsp_data.entry_index, want.entry_index);
            if (rsp_data.entry_live !== want.entry_live)
               report_mismatch("entry_live", rsp_data.entry_live, want.entry_live);
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   always @(negedge clock) begin
      stall_phase++;
      if (!hold_done && rsp_seen >= HOLD_AFTER) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 128);
         end
         mode_left--;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= stall_phase[2];
            default: rsp_stall <= ($urandom_range(0, 1) == 1);
         endcase
      end
   end

   initial begin
      int i;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tolerance is at its reset value of 10 here
      add_row(nlt_pkg::ACT_HEARTBEAT, 32'h0, 16'h0, 32'h0, 1'b1,
              nlt_pkg::STATUS_NOT_FOUND, 4'd0, 1'b0);
      add_row(nlt_pkg::ACT_QUIT, 32'h0, 16'h0, 32'h0, 1'b1,
              nlt_pkg::STATUS_NOT_FOUND, 4'd0, 1'b0);
      add_row(ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
              nlt_pkg::STATUS_NOT_FOUND, 4'd0, 1'b0);
      add_row(nlt_pkg::ACT_REGISTER, 32'h0, 16'h0, 32'h0, 1'b1,
              nlt_pkg::STATUS_REGISTERED, 4'd0, 1'b1);
      add_row(nlt_pkg::ACT_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
              nlt_pkg::STATUS_REGISTERED, 4'd1, 1'b1);
      add_row(nlt_pkg::ACT_HEARTBEAT, 32'h0, 16'h0, 32'd10, 1'b1,
              nlt_pkg::STATUS_IN_TIME, 4'd0, 1'b1);
      add_row(nlt_pkg::ACT_HEARTBEAT, 32'h0, 16'h0, 32'd21, 1'b1,
              nlt_pkg::STATUS_DEAD, 4'd0, 1'b0);
      // dead node stays dead on an in-time heartbeat
      add_row(nlt_pkg::ACT_HEARTBEAT, 32'h0, 16'h0, 32'd22, 1'b1,
              nlt_pkg::STATUS_IN_TIME, 4'd0, 1'b0);
      // timestamp wrap
      add_row(nlt_pkg::ACT_HEARTBEAT, 32'hFFFF_FFFF, 16'hFFFF, 32'd9, 1'b1,
              nlt_pkg::STATUS_IN_TIME, 4'd1, 1'b1);
      add_row(nlt_pkg::ACT_HEARTBEAT, 32'hFFFF_FFFF, 16'hFFFF, 32'd20, 1'b1,
              nlt_pkg::STATUS_DEAD, 4'd1, 1'b0);
      // duplicate registration, first match wins afterwards
      add_row(nlt_pkg::ACT_REGISTER, 32'h0, 16'h0, 32'd100, 1'b1,
              nlt_pkg::STATUS_REGISTERED, 4'd2, 1'b1);
      add_row(nlt_pkg::ACT_QUIT, 32'h0, 16'h0, 32'h0, 1'b1,
              nlt_pkg::STATUS_QUIT_DONE, 4'd0, 1'b0);
      add_row(nlt_pkg::ACT_HEARTBEAT, 32'h0, 16'h0, 32'd105, 1'b1,
              nlt_pkg::STATUS_DEAD, 4'd0, 1'b0);
      add_row(nlt_pkg::ACT_HEARTBEAT, 32'h0, 16'h1, 32'h0, 1'b1,
              nlt_pkg::STATUS_NOT_FOUND, 4'd0, 1'b0);
      add_row(nlt_pkg::ACT_HEARTBEAT, 32'h1, 16'h0, 32'h0, 1'b1,
              nlt_pkg::STATUS_NOT_FOUND, 4'd0, 1'b0);
      add_row(ACT_UNUSED, 32'h0, 16'h0, 32'd100, 1'b1,
              nlt_pkg::STATUS_NOT_FOUND, 4'd0, 1'b0);
      add_row(nlt_pkg::ACT_REGISTER, 32'h8000_0000, 16'h8000, 32'h8000_0000, 1'b1,
              nlt_pkg::STATUS_REGISTERED, 4'd3, 1'b1);
      add_row(nlt_pkg::ACT_QUIT, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 1'b1,
              nlt_pkg::STATUS_QUIT_DONE, 4'd1, 1'b0);
      add_row(nlt_pkg::ACT_HEARTBEAT, 32'h8000_0000, 16'h8000, 32'h8000_000A, 1'b0,
              '0, '0, 1'b0);
      add_row(nlt_pkg::ACT_HEARTBEAT, 32'h8000_0000, 16'h8000, 32'h7FFF_FFFF, 1'b0,
              '0, '0, 1'b0);
      add_row(nlt_pkg::ACT_REGISTER, $urandom, 16'($urandom), $urandom, 1'b0,
              '0, '0, 1'b0);

      for (i = 0; i < dir_rows.size(); i++) begin
         pause_sender($urandom_range(0, 3));
         send_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);
      end

      write_tolerance(32'hFFFF_FFFF);
      run_random_phase(PHASE_ITEMS);
      write_tolerance($urandom_range(1, 100));
      run_random_phase(PHASE_ITEMS);
      write_tolerance(nlt_pkg::TOLERANCE_RESET);
      run_random_phase(PHASE_ITEMS);
      write_tolerance($urandom);
      run_random_phase(PHASE_ITEMS);
      write_tolerance(32'h0);
      run_random_phase(PHASE_ITEMS);

      drain_responses();
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("node_liveness_table_unit_test: clean");
      end else begin
         $display("node_liveness_table_unit_test: errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/nlt_pkg.sv
hw/rtl/nlt_ram.sv
hw/rtl/nlt_ctrl.sv
hw/rtl/nlt_datapath.sv
hw/rtl/node_liveness_table_unit.sv
tb/sv/node_liveness_table_unit_test.sv
